// File: rtl/core/fsba_pkg.sv
// Package for the fixed-size block allocator: sizes, action and register
// codes, and the request, response and divider result types.
// Depends on nothing; the divider and the top level of the allocator import it.
package fsba_pkg;

    // Pool geometry.
    localparam int DEPTH      = 256;
    localparam int NODE_BYTES = 8;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Field and register widths.
    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 12;
    localparam int ACTION_W   = 2;
    localparam int CFG_IDX_W  = 2;

    // Action codes; the fourth code is unused and answered with a failure.
    localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_COUNT = 2'd2;

    // Configuration reset values.
    localparam logic [ADDR_W-1:0] POOL_BASE_RST  = '0;
    localparam logic [SIZE_W-1:0] UNIT_SIZE_RST  = 12'd8;
    localparam logic [CNT_W-1:0]  UNIT_COUNT_RST = CNT_W'(DEPTH);

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [ADDR_W-1:0]   address;
    } req_t;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] block_address;
        logic [CNT_W-1:0]  units_in_use;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] quotient;
        logic [SIZE_W-1:0] remainder;
    } div_result_t;

endpackage

// File: rtl/core/fsba_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Self-contained; used for the freed-unit stack and the ownership bits.
module fsba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/fsba_div.sv
// Serial restoring divider: one quotient bit per cycle over the address width.
// Depends on fsba_pkg for widths and the result type.
module fsba_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [fsba_pkg::ADDR_W-1:0] dividend,
    input  logic [fsba_pkg::SIZE_W-1:0] divisor,
    output logic                       done,
    output fsba_pkg::div_result_t      result
);

    import fsba_pkg::*;

    localparam int STEP_W = $clog2(ADDR_W + 1);

    logic [STEP_W-1:0] steps_reg;
    logic              done_reg;
    logic [ADDR_W-1:0] quo_reg;
    logic [SIZE_W-1:0] rem_reg;
    logic [SIZE_W-1:0] dsr_reg;
    logic [SIZE_W:0]   rem_shift;
    logic              fits;
    logic [SIZE_W:0]   rem_sub;

    // One restoring step: shift in the next dividend bit and trial-subtract.
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[ADDR_W-1]};
        fits      = rem_shift >= {1'b0, dsr_reg};
        rem_sub   = rem_shift - {1'b0, dsr_reg};
    end

    // Step counter and done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                steps_reg <= STEP_W'(ADDR_W);
            end
            else if (steps_reg != '0)
            begin
                steps_reg <= steps_reg - 1'b1;
                done_reg  <= steps_reg == STEP_W'(1);
            end
        end
    end

    // Datapath: quotient bits shift in where the dividend bits shift out.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (steps_reg != '0)
        begin
            quo_reg <= {quo_reg[ADDR_W-2:0], fits};
            rem_reg <= fits ? rem_sub[SIZE_W-1:0] : rem_shift[SIZE_W-1:0];
        end
    end

    assign done             = done_reg;
    assign result.quotient  = quo_reg;
    assign result.remainder = rem_reg;

endmodule

// File: rtl/core/fixed_size_block_allocator.sv
// Fixed-size block allocator: freed units kept on a LIFO stack in RAM, unused ones taken by a fresh index.
// Steps from acceptance to the result: allocate of a fresh unit runs the index multiply,
// then the address add; a stacked unit first reads the stack RAM; free runs the 32-step
// serial divider, then the check and the push; clear and early rejects answer from idle.
// A new start is taken at the edge that ends the done cycle; done lasts one cycle, no stall.
// Reset (rst_n, asynchronous) empties the pool and restores register defaults.
module fixed_size_block_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  fsba_pkg::req_t                req,
    output logic                          done,
    output fsba_pkg::rsp_t                rsp,
    input  logic                          cfg_write,
    input  logic [fsba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fsba_pkg::ADDR_W-1:0]   cfg_data
);

    import fsba_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC_RD,
        ST_ALLOC_MUL,
        ST_ALLOC_ADD,
        ST_DIV,
        ST_FREE_CHK,
        ST_FREE_DEC
    } state_t;

    state_t            state_reg;
    logic [ADDR_W-1:0] pool_base_reg;
    logic [SIZE_W-1:0] unit_size_reg;
    logic [CNT_W-1:0]  unit_count_reg;
    logic [CNT_W-1:0]  top_reg;
    logic [CNT_W-1:0]  fresh_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              done_reg;
    rsp_t              rsp_reg;

    logic [IDX_W-1:0]        idx_reg;
    logic [IDX_W+SIZE_W-1:0] prod_reg;
    logic                    chk_ok_reg;

    logic              accept;
    logic [CNT_W-1:0]  units_now;
    logic [ADDR_W-1:0] first_addr;
    logic              div_start;
    logic              div_done;
    div_result_t       div_res;
    logic [IDX_W-1:0]  stack_rdata;
    logic              owned_rdata;
    logic              owned_now;
    logic              free_hit;
    logic [CNT_W-1:0]  count_dec;
    logic              stack_we;
    logic              owned_we;
    logic [IDX_W-1:0]  owned_waddr;
    logic [IDX_W-1:0]  top_dec;

    // Handshake and pool geometry from the current registers.
    always_comb
    begin
        accept     = start && !busy;
        units_now  = (unit_count_reg > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : unit_count_reg;
        first_addr = pool_base_reg + ADDR_W'(units_now) * ADDR_W'(NODE_BYTES);
        div_start  = accept && (req.action == ACT_FREE) && (req.address != '0)
                     && (unit_size_reg != '0);
        top_dec    = IDX_W'(top_reg - 1'b1);
    end

    // An ownership entry at or above the fresh index has not been written since
    // the last clear, so it reads as not owned.
    always_comb
    begin
        owned_now = ({1'b0, idx_reg} < fresh_reg) && owned_rdata;
        free_hit  = chk_ok_reg && owned_now && (top_reg < CNT_W'(DEPTH));
        count_dec = (count_reg != '0) ? count_reg - 1'b1 : count_reg;
    end

    // Memory write control: an allocate marks its unit owned, a free clears it
    // and pushes the index.
    always_comb
    begin
        stack_we    = (state_reg == ST_FREE_DEC) && free_hit;
        owned_we    = (state_reg == ST_ALLOC_MUL) || stack_we;
        owned_waddr = idx_reg;
    end

    fsba_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (req.address - first_addr),
        .divisor  (unit_size_reg),
        .done     (div_done),
        .result   (div_res)
    );

    fsba_ram #(
        .WIDTH (IDX_W),
        .DEPTH (DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stack_we),
        .waddr (top_reg[IDX_W-1:0]),
        .wdata (idx_reg),
        .raddr (top_dec),
        .rdata (stack_rdata)
    );

    fsba_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_owned_ram (
        .clk   (clk),
        .we    (owned_we),
        .waddr (owned_waddr),
        .wdata (state_reg == ST_ALLOC_MUL),
        .raddr (div_res.quotient[IDX_W-1:0]),
        .rdata (owned_rdata)
    );

    // Sequencer, pool counters, configuration and the response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pool_base_reg  <= POOL_BASE_RST;
            unit_size_reg  <= UNIT_SIZE_RST;
            unit_count_reg <= UNIT_COUNT_RST;
            top_reg        <= '0;
            fresh_reg      <= '0;
            count_reg      <= '0;
            done_reg       <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            done_reg <= 1'b0;

            // Configuration writes; an index beyond the list is ignored.
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_POOL_BASE:  pool_base_reg  <= cfg_data;
                    REG_UNIT_SIZE:  unit_size_reg  <= cfg_data[SIZE_W-1:0];
                    REG_UNIT_COUNT: unit_count_reg <= cfg_data[CNT_W-1:0];
                    default:        ;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        rsp_reg.ok            <= 1'b0;
                        rsp_reg.block_address <= '0;
                        rsp_reg.units_in_use  <= count_reg;
                        case (req.action)
                            ACT_ALLOC:
                            begin
                                if (top_reg != '0)
                                begin
                                    top_reg   <= top_reg - 1'b1;
                                    count_reg <= count_reg + 1'b1;
                                    state_reg <= ST_ALLOC_RD;
                                end
                                else if (fresh_reg < units_now)
                                begin
                                    fresh_reg <= fresh_reg + 1'b1;
                                    count_reg <= count_reg + 1'b1;
                                    state_reg <= ST_ALLOC_MUL;
                                end
                                else
                                begin
                                    done_reg <= 1'b1;
                                end
                            end
                            ACT_FREE:
                            begin
                                if (div_start)
                                begin
                                    state_reg <= ST_DIV;
                                end
                                else
                                begin
                                    done_reg <= 1'b1;
                                end
                            end
                            ACT_CLEAR:
                            begin
                                top_reg              <= '0;
                                fresh_reg            <= '0;
                                count_reg            <= '0;
                                rsp_reg.ok           <= 1'b1;
                                rsp_reg.units_in_use <= '0;
                                done_reg             <= 1'b1;
                            end
                            default:
                            begin
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_ALLOC_RD:
                begin
                    state_reg <= ST_ALLOC_MUL;
                end
                ST_ALLOC_MUL:
                begin
                    state_reg <= ST_ALLOC_ADD;
                end
                ST_ALLOC_ADD:
                begin
                    rsp_reg.ok            <= 1'b1;
                    rsp_reg.block_address <= first_addr + ADDR_W'(prod_reg);
                    rsp_reg.units_in_use  <= count_reg;
                    done_reg              <= 1'b1;
                    state_reg             <= ST_IDLE;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_FREE_CHK;
                    end
                end
                ST_FREE_CHK:
                begin
                    state_reg <= ST_FREE_DEC;
                end
                ST_FREE_DEC:
                begin
                    if (free_hit)
                    begin
                        top_reg              <= top_reg + 1'b1;
                        count_reg            <= count_dec;
                        rsp_reg.ok           <= 1'b1;
                        rsp_reg.units_in_use <= count_dec;
                    end
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers: the unit index, its scaled offset and the free check.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                idx_reg <= fresh_reg[IDX_W-1:0];
            end
            ST_ALLOC_RD:
            begin
                idx_reg <= stack_rdata;
            end
            ST_ALLOC_MUL:
            begin
                prod_reg <= (IDX_W+SIZE_W)'(idx_reg) * (IDX_W+SIZE_W)'(unit_size_reg);
            end
            ST_FREE_CHK:
            begin
                idx_reg    <= div_res.quotient[IDX_W-1:0];
                chk_ok_reg <= (div_res.remainder == '0)
                              && (div_res.quotient < ADDR_W'(units_now));
            end
            default:
            begin
            end
        endcase
    end

    assign busy = state_reg != ST_IDLE;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // Every fresh index handed out is either in use or waiting on the stack.
    a_count_balance: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, count_reg} + {1'b0, top_reg}) == {1'b0, fresh_reg})
        else $error("in-use count and stack depth do not add up to the fresh index");

    // The stack and the fresh index never pass the pool depth.
    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (top_reg <= CNT_W'(DEPTH)) && (fresh_reg <= CNT_W'(DEPTH)))
        else $error("stack pointer or fresh index beyond pool depth");

    // The divider only finishes while a free is waiting on it.
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside a free");

    // Every response leaves the sequencer ready for the next transfer.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("response strobed while still busy");

endmodule
